// ----- src/urd_pkg.sv -----
// Package for the unsigned restoring divider: operand width and the
// record that travels down the row of divider cells. No dependencies.
package urd_pkg;

    localparam int WIDTH = 8;

    // Per-stage record: operands, partial remainder and quotient so far.
    typedef struct packed {
        logic [WIDTH-1:0] dividend;   // unconsumed dividend bits, MSB first
        logic [WIDTH-1:0] divisor;
        logic [WIDTH-1:0] part_rem;   // partial remainder
        logic [WIDTH-1:0] quot;       // quotient bits produced so far
        logic             div_zero;
    } urd_stage_t;

endpackage

// ----- src/urd_if.sv -----
// Valid/ready channel interfaces for the divider request and result.
// Depends on urd_pkg for the operand width.
interface urd_req_if;
    logic                     valid;
    logic                     ready;
    logic [urd_pkg::WIDTH-1:0] dividend;
    logic [urd_pkg::WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface urd_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [urd_pkg::WIDTH-1:0] quotient;
    logic [urd_pkg::WIDTH-1:0] remainder;
    logic                     divide_by_zero;

    modport source (output valid, output quotient, output remainder,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input divide_by_zero, output ready);
endinterface

// ----- src/urd_cell.sv -----
// One restoring-division step with its own stage register and handshake.
// Depends on urd_pkg for urd_stage_t and WIDTH.
module urd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  urd_pkg::urd_stage_t up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output urd_pkg::urd_stage_t dn_data
);
    import urd_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    urd_stage_t       data_reg;
    urd_stage_t       data_next;
    logic [WIDTH-1:0] shifted;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        // Shift next dividend bit in; bit WIDTH of the trial sits in the old MSB.
        shifted = {up_data.part_rem[WIDTH-2:0], up_data.dividend[WIDTH-1]};
        diff    = {up_data.part_rem[WIDTH-1], shifted} - {1'b0, up_data.divisor};
        fits    = !diff[WIDTH];

        data_next.dividend = {up_data.dividend[WIDTH-2:0], 1'b0};
        data_next.divisor  = up_data.divisor;
        data_next.part_rem = fits ? diff[WIDTH-1:0] : shifted;
        data_next.quot     = {up_data.quot[WIDTH-2:0], fits};
        data_next.div_zero = up_data.div_zero;

        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload only when a request moves in.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- src/unsigned_restoring_divider_unit.sv -----
// Unsigned restoring divider: a row of WIDTH urd_cell stages.
// Depends on urd_pkg, urd_if and urd_cell.
//
// Usage:
//   req carries dividend and divisor; a request is taken when valid and
//   ready are both high. rsp carries quotient, remainder and divide_by_zero
//   under the same valid/ready rule.
//   Each cell resolves one quotient bit, MSB first, in its own register.
//   One request per cycle is taken in steady state while rsp.ready stays
//   high; every cell holds one division in flight, so up to WIDTH
//   divisions overlap.
//   A zero divisor gives an all-ones quotient, the dividend as remainder and
//   divide_by_zero set.
//   When the receiver stalls, the last cell holds its result and the cells
//   behind it keep filling empty slots; req.ready drops only once every
//   cell holds a division.
//   Reset empties every cell; no result is pending afterwards and requests
//   can be taken as soon as reset is released.
module unsigned_restoring_divider_unit (
    input  logic       clk,
    input  logic       rst_n,
    urd_req_if.sink    req,
    urd_rsp_if.source  rsp
);
    import urd_pkg::*;

    logic       valid_chain [WIDTH+1];
    logic       ready_chain [WIDTH+1];
    urd_stage_t data_chain  [WIDTH+1];

    always_comb
    begin
        data_chain[0].dividend = req.dividend;
        data_chain[0].divisor  = req.divisor;
        data_chain[0].part_rem = '0;
        data_chain[0].quot     = '0;
        data_chain[0].div_zero = (req.divisor == '0);
    end

    assign valid_chain[0] = req.valid;
    assign req.ready      = ready_chain[0];

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        urd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_chain[i]),
            .up_ready (ready_chain[i]),
            .up_data  (data_chain[i]),
            .dn_valid (valid_chain[i+1]),
            .dn_ready (ready_chain[i+1]),
            .dn_data  (data_chain[i+1])
        );
    end

    assign rsp.valid          = valid_chain[WIDTH];
    assign ready_chain[WIDTH] = rsp.ready;
    assign rsp.quotient       = data_chain[WIDTH].quot;
    assign rsp.remainder      = data_chain[WIDTH].part_rem;
    assign rsp.divide_by_zero = data_chain[WIDTH].div_zero;

endmodule

// ----- src/urd_checker.sv -----
// Port-level checks for unsigned_restoring_divider_unit, bound to the top.
// Depends on urd_pkg for WIDTH.
module urd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [urd_pkg::WIDTH-1:0] quotient,
    input logic [urd_pkg::WIDTH-1:0] remainder,
    input logic                      divide_by_zero
);
    import urd_pkg::*;

    // Hold a stalled result.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(quotient) && $stable(remainder))
        else $error("stalled result changed");

    // Back-pressure on requests only comes from a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request refused without a stalled result");

    a_dz_quot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && divide_by_zero |-> quotient == {WIDTH{1'b1}})
        else $error("zero divisor without all-ones quotient");

endmodule

bind unsigned_restoring_divider_unit urd_checker u_urd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .quotient       (rsp.quotient),
    .remainder      (rsp.remainder),
    .divide_by_zero (rsp.divide_by_zero)
);
